@@ rtl/core/spcv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the tone voice: register map, queue item,
// sequencer states and fixed-point constants. No dependencies.
package spcv_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int INDEX_BITS      = 20;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

   // Quarter-wave polynomial coefficients, Q1.15
   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [15:0] SIN_B = 16'd21024;
   localparam logic [15:0] SIN_C = 16'd2320;

   localparam logic [15:0] AMP_RESET    = 16'd32768;
   localparam logic [15:0] ATTACK_RESET = 16'd176;
   localparam logic [19:0] LENGTH_RESET = 20'd1;

   typedef enum logic {
      OP_TICK,
      OP_RESTART
   } spcv_op_type;

   typedef struct packed {
      logic        valid;
      spcv_op_type op;
   } spcv_item_type;

   typedef enum logic {
      MODE_PARTIAL,
      MODE_CHIRP
   } spcv_mode_type;

   typedef enum logic [2:0] {
      REG_MODE,
      REG_STEP_START,
      REG_STEP_DELTA,
      REG_AMPLITUDE,
      REG_DECAY,
      REG_ATTACK_LEN,
      REG_RAMP_STEP,
      REG_LENGTH
   } spcv_reg_type;

   typedef struct packed {
      spcv_mode_type mode;
      logic [30:0]   phase_step_start;
      logic [24:0]   phase_step_delta;
      logic [15:0]   amplitude;
      logic [31:0]   decay_factor;
      logic [15:0]   attack_len;
      logic [31:0]   ramp_step;
      logic [19:0]   length;
   } spcv_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GAIN,
      ST_ENV,
      ST_Z2,
      ST_C,
      ST_B,
      ST_A,
      ST_SIN,
      ST_G,
      ST_MAG,
      ST_OUT
   } spcv_state_type;

endpackage

@@ rtl/core/spcv_csr.sv @@
`timescale 1ns / 1ps
// Configuration register file of the tone voice, APB-style access.
// Depends on spcv_pkg.
module spcv_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [spcv_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [spcv_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [spcv_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output spcv_pkg::spcv_cfg_type              cfg
);

   spcv_pkg::spcv_cfg_type cfg_ff;
   spcv_pkg::spcv_cfg_type cfg_in;
   spcv_pkg::spcv_reg_type reg_sel;
   logic                   wr_en;

   assign reg_sel    = spcv_pkg::spcv_reg_type'(csr_paddr[spcv_pkg::CSR_ADDR_BITS-1:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            spcv_pkg::REG_MODE:       cfg_in.mode = spcv_pkg::spcv_mode_type'(csr_pwdata[0]);
            spcv_pkg::REG_STEP_START: cfg_in.phase_step_start = csr_pwdata[30:0];
            spcv_pkg::REG_STEP_DELTA: cfg_in.phase_step_delta = csr_pwdata[24:0];
            spcv_pkg::REG_AMPLITUDE:  cfg_in.amplitude = csr_pwdata[15:0];
            spcv_pkg::REG_DECAY:      cfg_in.decay_factor = csr_pwdata[31:0];
            spcv_pkg::REG_ATTACK_LEN: cfg_in.attack_len = csr_pwdata[15:0];
            spcv_pkg::REG_RAMP_STEP:  cfg_in.ramp_step = csr_pwdata[31:0];
            spcv_pkg::REG_LENGTH:     cfg_in.length = csr_pwdata[19:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         spcv_pkg::REG_MODE:       csr_prdata = 32'(cfg_ff.mode);
         spcv_pkg::REG_STEP_START: csr_prdata = 32'(cfg_ff.phase_step_start);
         spcv_pkg::REG_STEP_DELTA: csr_prdata = 32'(cfg_ff.phase_step_delta);
         spcv_pkg::REG_AMPLITUDE:  csr_prdata = 32'(cfg_ff.amplitude);
         spcv_pkg::REG_DECAY:      csr_prdata = cfg_ff.decay_factor;
         spcv_pkg::REG_ATTACK_LEN: csr_prdata = 32'(cfg_ff.attack_len);
         spcv_pkg::REG_RAMP_STEP:  csr_prdata = cfg_ff.ramp_step;
         spcv_pkg::REG_LENGTH:     csr_prdata = 32'(cfg_ff.length);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode             <= spcv_pkg::MODE_PARTIAL;
         cfg_ff.phase_step_start <= '0;
         cfg_ff.phase_step_delta <= '0;
         cfg_ff.amplitude        <= spcv_pkg::AMP_RESET;
         cfg_ff.decay_factor     <= spcv_pkg::ONE_Q31;
         cfg_ff.attack_len       <= spcv_pkg::ATTACK_RESET;
         cfg_ff.ramp_step        <= '0;
         cfg_ff.length           <= spcv_pkg::LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/spcv_front.sv @@
`timescale 1ns / 1ps
// Front end of the tone voice: takes request beats, classifies them as
// restart or tick and holds them in a short queue. Depends on spcv_pkg.
module spcv_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_restart,
   output logic                    req_stall,
   output spcv_pkg::spcv_item_type head,
   input  logic                    pop
);

   localparam int PB = spcv_pkg::QUEUE_PTR_BITS;

   spcv_pkg::spcv_op_type op_ff [spcv_pkg::QUEUE_DEPTH];
   logic [PB-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PB:0]           count_ff, count_in;
   logic                  push;
   spcv_pkg::spcv_op_type push_op;

   assign req_stall = (count_ff == (PB+1)'(spcv_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign push_op   = req_restart ? spcv_pkg::OP_RESTART : spcv_pkg::OP_TICK;

   assign head.valid = (count_ff != '0);
   assign head.op    = op_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(spcv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PB'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(spcv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PB'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PB+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PB+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/spcv_back.sv @@
`timescale 1ns / 1ps
// Back end of the tone voice: sequencer around one shared 32x32 multiplier,
// voice state, sine polynomial, envelope and output register. Depends on spcv_pkg.
module spcv_back #(
   parameter int SINE_TABLE_BITS = spcv_pkg::SINE_TABLE_BITS,
   parameter int INDEX_BITS      = spcv_pkg::INDEX_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spcv_pkg::spcv_cfg_type  cfg,
   input  spcv_pkg::spcv_item_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [15:0]      rsp_sample,
   output logic                    rsp_active,
   output logic                    rsp_last
);

   localparam int QB       = SINE_TABLE_BITS - 2;
   localparam int ZSHIFT   = 15 - QB;
   localparam int CMP_BITS = (INDEX_BITS > 16) ? INDEX_BITS : 16;

   spcv_pkg::spcv_state_type state_ff, state_in;

   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [31:0] phase_ff, phase_in;
   logic [31:0] step_ff, step_in;
   logic [31:0] env_ff, env_in;
   logic [31:0] ramp_ff, ramp_in;

   logic [31:0] ang_ff, ang_in;
   logic [63:0] p_ff, p_in;
   logic        p_load;
   logic [15:0] z2_ff, z2_in;
   logic [15:0] smag_ff, smag_in;
   logic        sneg_ff, sneg_in;
   logic [15:0] e_ff, e_in;
   logic        pass_ff, pass_in;
   logic        active_ff, active_in;
   logic        last_ff, last_in;
   logic        attack_ff, attack_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_active_ff, rsp_active_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [31:0] mul_a, mul_b;

   // Angle folding into the first quadrant
   logic [SINE_TABLE_BITS-1:0] ang_idx;
   logic [QB:0]                r_fold;
   logic [15:0]                z;

   logic [INDEX_BITS-1:0] len;
   logic [31:0]           gain;
   logic [32:0]           ramp_sum;
   logic [31:0]           ramp_next;
   logic [31:0]           delta_sext;
   logic [48:0]           mag;
   logic signed [15:0]    sample_val;
   logic                  out_free;

   assign ang_idx = ang_ff[31 -: SINE_TABLE_BITS];
   assign r_fold  = ang_idx[SINE_TABLE_BITS-2]
                    ? ((QB+1)'(1) << QB) - {1'b0, ang_idx[QB-1:0]}
                    : {1'b0, ang_idx[QB-1:0]};
   assign z       = 16'(r_fold) << ZSHIFT;

   assign len        = INDEX_BITS'(cfg.length);
   assign gain       = attack_ff ? p_ff[62:31] : env_ff;
   assign ramp_sum   = {1'b0, ramp_ff} + {1'b0, cfg.ramp_step};
   assign ramp_next  = (ramp_sum > {1'b0, spcv_pkg::ONE_Q31}) ? spcv_pkg::ONE_Q31
                                                               : ramp_sum[31:0];
   assign delta_sext = {{7{cfg.phase_step_delta[24]}}, cfg.phase_step_delta};
   assign mag        = p_ff[63:15];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign p_in       = mul_a * mul_b;

   always_comb begin
      if (!active_ff) begin
         sample_val = '0;
      end else if (sneg_ff) begin
         sample_val = (mag >= 49'd32768) ? 16'sh8000 : signed'(16'd0 - mag[15:0]);
      end else begin
         sample_val = (mag >= 49'd32767) ? 16'sh7FFF : signed'(mag[15:0]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      env_in        = env_ff;
      ramp_in       = ramp_ff;
      ang_in        = ang_ff;
      z2_in         = z2_ff;
      smag_in       = smag_ff;
      sneg_in       = sneg_ff;
      e_in          = e_ff;
      pass_in       = pass_ff;
      active_in     = active_ff;
      last_in       = last_ff;
      attack_in     = attack_ff;
      pop           = 1'b0;
      p_load        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      rsp_sample_in = rsp_sample_ff;
      rsp_active_in = rsp_active_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         spcv_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.op == spcv_pkg::OP_RESTART) begin
                  idx_in   = '0;
                  phase_in = '0;
                  step_in  = {1'b0, cfg.phase_step_start};
                  env_in   = spcv_pkg::ONE_Q31;
                  ramp_in  = '0;
               end
               state_in = spcv_pkg::ST_CHECK;
            end
         end
         spcv_pkg::ST_CHECK: begin
            active_in = (idx_ff < len);
            last_in   = (idx_ff == len - INDEX_BITS'(1));
            attack_in = (CMP_BITS'(idx_ff) < CMP_BITS'(cfg.attack_len));
            pass_in   = 1'b0;
            if (!(idx_ff < len)) begin
               state_in = spcv_pkg::ST_OUT;
            end else if (cfg.mode == spcv_pkg::MODE_PARTIAL) begin
               ang_in   = phase_ff;
               state_in = spcv_pkg::ST_GAIN;
            end else begin
               // Chirp advances phase before the lookup
               phase_in = phase_ff + step_ff;
               ang_in   = phase_ff + step_ff;
               state_in = spcv_pkg::ST_Z2;
            end
         end
         spcv_pkg::ST_GAIN: begin
            p_load   = 1'b1;
            mul_a    = env_ff;
            mul_b    = ramp_ff;
            state_in = spcv_pkg::ST_ENV;
         end
         spcv_pkg::ST_ENV: begin
            e_in     = gain[31:16];
            p_load   = 1'b1;
            mul_a    = env_ff;
            mul_b    = cfg.decay_factor;
            state_in = spcv_pkg::ST_Z2;
         end
         spcv_pkg::ST_Z2: begin
            // Partial mode: the product holds envelope times decay
            if (cfg.mode == spcv_pkg::MODE_PARTIAL) begin
               env_in = (p_ff[63:31] > {1'b0, spcv_pkg::ONE_Q31}) ? spcv_pkg::ONE_Q31
                                                                   : p_ff[62:31];
            end
            p_load   = 1'b1;
            mul_a    = 32'(z);
            mul_b    = 32'(z);
            state_in = spcv_pkg::ST_C;
         end
         spcv_pkg::ST_C: begin
            z2_in    = p_ff[30:15];
            p_load   = 1'b1;
            mul_a    = 32'(spcv_pkg::SIN_C);
            mul_b    = 32'(p_ff[30:15]);
            state_in = spcv_pkg::ST_B;
         end
         spcv_pkg::ST_B: begin
            p_load   = 1'b1;
            mul_a    = 32'(z2_ff);
            mul_b    = 32'(spcv_pkg::SIN_B - p_ff[30:15]);
            state_in = spcv_pkg::ST_A;
         end
         spcv_pkg::ST_A: begin
            p_load   = 1'b1;
            mul_a    = 32'(z);
            mul_b    = 32'(spcv_pkg::SIN_A - p_ff[30:15]);
            state_in = spcv_pkg::ST_SIN;
         end
         spcv_pkg::ST_SIN: begin
            if (!pass_ff) begin
               smag_in = p_ff[30:15];
               sneg_in = ang_ff[31];
               if (cfg.mode == spcv_pkg::MODE_CHIRP) begin
                  // Second pass: half-sine envelope from the ramp
                  pass_in  = 1'b1;
                  ang_in   = ramp_ff;
                  state_in = spcv_pkg::ST_Z2;
               end else begin
                  state_in = spcv_pkg::ST_G;
               end
            end else begin
               e_in     = p_ff[30:15];
               state_in = spcv_pkg::ST_G;
            end
         end
         spcv_pkg::ST_G: begin
            p_load   = 1'b1;
            mul_a    = 32'(cfg.amplitude);
            mul_b    = 32'(e_ff);
            state_in = spcv_pkg::ST_MAG;
         end
         spcv_pkg::ST_MAG: begin
            p_load   = 1'b1;
            mul_a    = p_ff[46:15];
            mul_b    = 32'(smag_ff);
            state_in = spcv_pkg::ST_OUT;
         end
         spcv_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_val;
               rsp_active_in = active_ff;
               rsp_last_in   = active_ff && last_ff;
               if (active_ff) begin
                  if (cfg.mode == spcv_pkg::MODE_PARTIAL) begin
                     phase_in = phase_ff + step_ff;
                  end else begin
                     step_in = step_ff + delta_sext;
                  end
                  ramp_in = ramp_next;
                  idx_in  = idx_ff + INDEX_BITS'(1);
               end
               state_in = spcv_pkg::ST_IDLE;
            end
         end
         default: state_in = spcv_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spcv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= INDEX_BITS'(spcv_pkg::LENGTH_RESET);
         phase_ff     <= '0;
         step_ff      <= '0;
         env_ff       <= spcv_pkg::ONE_Q31;
         ramp_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         env_ff       <= env_in;
         ramp_ff      <= ramp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_load) begin
         p_ff <= p_in;
      end
      ang_ff        <= ang_in;
      z2_ff         <= z2_in;
      smag_ff       <= smag_in;
      sneg_ff       <= sneg_in;
      e_ff          <= e_in;
      pass_ff       <= pass_in;
      active_ff     <= active_in;
      last_ff       <= last_in;
      attack_ff     <= attack_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_active_ff <= rsp_active_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_active = rsp_active_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ rtl/core/sine_partial_and_chirp_voice.sv @@
`timescale 1ns / 1ps
// Tone voice top level: one 16-bit sample per request beat.
// Partial mode runs the sine polynomial once, chirp mode twice; an inactive tick goes straight to the output.
// The back sequencer handles one beat at a time and runs every product through one shared
// 32x32 multiplier; the front queue holds further beats meanwhile.
// Reset (synchronous, active high): registers to defaults, queue and output empty, voice inactive.
module sine_partial_and_chirp_voice #(
   parameter int SINE_TABLE_BITS = spcv_pkg::SINE_TABLE_BITS,
   parameter int INDEX_BITS      = spcv_pkg::INDEX_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel: one beat is one sample tick
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_sample,
   output logic                                rsp_active,
   output logic                                rsp_last,
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [spcv_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [spcv_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [spcv_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   spcv_pkg::spcv_cfg_type  cfg;
   spcv_pkg::spcv_item_type head;
   logic                    back_pop;

   // Register file; the user must hold values stable while a beat is in flight (not enforced here)
   spcv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Front: classify each beat as restart or tick and queue it, so the
   // request side keeps moving while the back end computes, until the queue is full
   spcv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .head        (head),
      .pop         (back_pop)
   );

   // Back: pop one item, apply restart, check activity, then step the
   // envelope and sine polynomial through the shared multiplier and
   // hand the saturated sample to the output register
   spcv_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .INDEX_BITS      (INDEX_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .pop        (back_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample),
      .rsp_active (rsp_active),
      .rsp_last   (rsp_last)
   );

   // An inactive result carries a silent sample and no last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_sample == 16'sd0 && !rsp_last)
      else $error("inactive beat carries nonzero sample or last");

   // The last flag only marks a playing sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_active)
      else $error("last flag on inactive beat");

   // The back end never drains an empty queue
   assert property (@(posedge clock) disable iff (reset)
      back_pop |-> head.valid)
      else $error("pop from empty queue");

endmodule
